// ===== src/ubxp_pkg.sv =====
// Shared types and constants for the UBX NAV-PVT frame parser.
// No dependencies; used by every module in src.
package ubxp_pkg;

  localparam int unsigned DEF_PAYLOAD_BYTES = 128;

  localparam int unsigned LEN_W = 16;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] NAV_CLASS   = 8'h01;
  localparam logic [7:0] PVT_ID      = 8'h07;
  localparam logic [LEN_W-1:0] PVT_MIN_LENGTH = 16'd92;

  // payload offsets read by a fix
  localparam logic [LEN_W-1:0] OFS_FIX_TYPE = 16'd20;
  localparam logic [LEN_W-1:0] OFS_NUM_SV   = 16'd23;

  localparam int unsigned NUM_WORDS = 7;
  localparam int unsigned W_LON    = 0;
  localparam int unsigned W_LAT    = 1;
  localparam int unsigned W_HEIGHT = 2;
  localparam int unsigned W_HACC   = 3;
  localparam int unsigned W_VACC   = 4;
  localparam int unsigned W_SPEED  = 5;
  localparam int unsigned W_HEAD   = 6;
  localparam int unsigned WORD_OFS [NUM_WORDS] = '{24, 28, 32, 40, 44, 60, 64};

  // raw fix type codes
  localparam logic [7:0] FIX_RAW_2D    = 8'd2;
  localparam logic [7:0] FIX_RAW_3D    = 8'd3;
  localparam logic [7:0] FIX_RAW_GNSS_DR = 8'd4;

  typedef enum logic [2:0] {
    ST_INCOMPLETE  = 3'd0,
    ST_OK          = 3'd1,
    ST_CHECKSUM    = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_MALFORMED   = 3'd4
  } ubxp_status_t;

  typedef enum logic [1:0] {
    FIX_NONE = 2'd0,
    FIX_2D   = 2'd1,
    FIX_3D   = 2'd2
  } ubxp_fix_kind_t;

  typedef struct packed {
    ubxp_status_t        status;
    ubxp_fix_kind_t      fix_kind;
    logic [7:0]          satellite_count;
    logic signed [30:0]  latitude;
    logic signed [31:0]  longitude;
    logic signed [31:0]  height;
    logic [31:0]         horiz_accuracy;
    logic [31:0]         vert_accuracy;
    logic signed [31:0]  ground_speed;
    logic signed [31:0]  heading;
    logic [63:0]         fix_time;
  } ubxp_result_t;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_FIELDS_W = 297;
  localparam int unsigned OUT_TDATA_W = 304;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int unsigned OUT_TUSER_W = 3;

endpackage

// ===== src/ubx_nav_pvt_frame_parser.sv =====
// UBX NAV-PVT frame parser, top level: decoder plus output buffer.
// Depends on ubxp_pkg, ubxp_frame_fsm and ubxp_out_buf.
//
//  channel | dir | tdata                         | tuser
//  in_     | in  | rx_byte, arrival_time         | -
//  out_    | out | fix_kind .. fix_time (304 b)  | status
//
// Each byte taken yields one result beat, registered into the output register, or into
// the skid stage while the output stalls. Sustained one beat per clock while in_tready is high.
// Reset (rst_n low, synchronous) returns to the sync hunt with sums cleared.
// An output stall is absorbed by a skid stage; in_tready falls only when it is full.
module ubx_nav_pvt_frame_parser import ubxp_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // rx_byte[7:0], arrival_time[71:8]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // fix_kind[1:0], satellite_count[9:2], latitude[40:10], longitude[72:41],
  // height[104:73], horiz_accuracy[136:105], vert_accuracy[168:137],
  // ground_speed[200:169], heading[232:201], fix_time[296:233], zero pad above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser   // status[2:0]
);

  ubxp_result_t res, res_q;
  logic         acc;

  assign acc = in_tvalid && in_tready;

  ubxp_frame_fsm #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .rx_byte      (in_tdata[7:0]),
    .arrival_time (in_tdata[71:8]),
    .result       (res)
  );

  ubxp_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_q)
  );

  assign out_tuser = res_q.status;
  assign out_tdata = {OUT_PAD_W'(0), res_q.fix_time, res_q.heading, res_q.ground_speed,
                      res_q.vert_accuracy, res_q.horiz_accuracy, res_q.height,
                      res_q.longitude, res_q.latitude, res_q.satellite_count,
                      res_q.fix_kind};

endmodule

// ===== src/ubxp_frame_fsm.sv =====
// Byte-wise UBX frame decoder: sync hunt, header, Fletcher checksum and
// capture of the NAV-PVT fields. Depends on ubxp_pkg.
module ubxp_frame_fsm import ubxp_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         acc,
  input  logic [7:0]   rx_byte,
  input  logic [63:0]  arrival_time,
  output ubxp_result_t result
);

  typedef enum logic [3:0] {
    PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI,
    PH_PAYLOAD, PH_CK_A, PH_CK_B
  } phase_t;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PAYLOAD_BYTES);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [7:0]       class_r, class_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;

  // captured payload fields, no reset: a frame long enough for a fix
  // rewrites all of them before its checksum
  logic [7:0]       fix_raw_r;
  logic [7:0]       num_sv_r;
  logic [31:0]      words_r [NUM_WORDS];

  logic [7:0]       sa_acc, sb_acc;
  logic [LEN_W-1:0] pos_inc, len_full;
  logic [31:0]      lat_raw;
  logic [30:0]      lat_sat;
  ubxp_fix_kind_t   kind;

  assign sa_acc   = sum_a_r + rx_byte;
  assign sb_acc   = sum_b_r + sa_acc;
  assign pos_inc  = pos_r + LEN_W'(1);
  assign len_full = {rx_byte, len_r[7:0]};

  assign lat_raw = words_r[W_LAT];
  always_comb begin
    case (lat_raw[31:30])
      2'b01:   lat_sat = 31'h3FFF_FFFF;
      2'b10:   lat_sat = 31'h4000_0000;
      default: lat_sat = lat_raw[30:0];
    endcase
  end

  always_comb begin
    case (fix_raw_r) inside
      FIX_RAW_2D:                  kind = FIX_2D;
      FIX_RAW_3D, FIX_RAW_GNSS_DR: kind = FIX_3D;
      default:                     kind = FIX_NONE;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    result    = '0;
    result.status = ST_INCOMPLETE;

    case (phase_r)
      PH_SYNC1: begin
        phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
          phase_nxt = PH_CLASS;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        class_nxt = rx_byte;
        sum_a_nxt = sa_acc;
        sum_b_nxt = sb_acc;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_a_nxt = sa_acc;
        sum_b_nxt = sb_acc;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'h00, rx_byte};
        sum_a_nxt = sa_acc;
        sum_b_nxt = sb_acc;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = len_full;
        sum_a_nxt = sa_acc;
        sum_b_nxt = sb_acc;
        pos_nxt   = '0;
        phase_nxt = (len_full == '0) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_a_nxt = sa_acc;
        sum_b_nxt = sb_acc;
        pos_nxt   = pos_inc;
        if (pos_inc >= len_r) phase_nxt = PH_CK_A;
      end
      PH_CK_A: begin
        if (rx_byte != sum_a_r) begin
          phase_nxt = PH_SYNC1;
          len_nxt   = '0;
          pos_nxt   = '0;
          result.status = ST_CHECKSUM;
        end else begin
          phase_nxt = PH_CK_B;
        end
      end
      PH_CK_B: begin
        phase_nxt = PH_SYNC1;
        len_nxt   = '0;
        pos_nxt   = '0;
        if (rx_byte != sum_b_r) begin
          result.status = ST_CHECKSUM;
        end else if (class_r != NAV_CLASS || id_r != PVT_ID) begin
          result.status = ST_UNSUPPORTED;
        end else if (len_r < PVT_MIN_LENGTH || len_r > MAX_LEN) begin
          result.status = ST_MALFORMED;
        end else begin
          result.status          = ST_OK;
          result.fix_kind        = kind;
          result.satellite_count = num_sv_r;
          result.latitude        = lat_sat;
          result.longitude       = words_r[W_LON];
          result.height          = words_r[W_HEIGHT];
          result.horiz_accuracy  = words_r[W_HACC];
          result.vert_accuracy   = words_r[W_VACC];
          result.ground_speed    = words_r[W_SPEED];
          result.heading         = words_r[W_HEAD];
          result.fix_time        = arrival_time;
        end
      end
      default: begin
        phase_nxt = PH_SYNC1;
        len_nxt   = '0;
        pos_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      sum_a_r <= '0;
      sum_b_r <= '0;
      class_r <= '0;
      id_r    <= '0;
      len_r   <= '0;
      pos_r   <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // field capture at fixed payload offsets
  always_ff @(posedge clk) begin
    if (acc && phase_r == PH_PAYLOAD) begin
      if (pos_r == OFS_FIX_TYPE) fix_raw_r <= rx_byte;
      if (pos_r == OFS_NUM_SV)   num_sv_r  <= rx_byte;
      for (int w = 0; w < NUM_WORDS; w++) begin
        for (int k = 0; k < 4; k++) begin
          if (pos_r == LEN_W'(WORD_OFS[w] + k)) words_r[w][8*k +: 8] <= rx_byte;
        end
      end
    end
  end

  a_bad_ck_a_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == PH_CK_A && rx_byte != sum_a_r) |=> phase_r == PH_SYNC1)
    else $error("bad first checksum byte did not restart the hunt");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> pos_r < len_r)
    else $error("payload position past frame length");

  a_ok_only_at_ck_b: assert property (@(posedge clk) disable iff (!rst_n)
    (result.status == ST_OK) |-> (phase_r == PH_CK_B && rx_byte == sum_b_r))
    else $error("fix reported outside the second checksum byte");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (result.status != ST_OK) |-> (result.fix_time == '0 && result.latitude == '0))
    else $error("fix fields not cleared on a non-ok status");

endmodule

// ===== src/ubxp_out_buf.sv =====
// Two-entry result buffer: output register plus skid stage, so the input
// side keeps taking beats while a result waits. Depends on ubxp_pkg.
module ubxp_out_buf import ubxp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  ubxp_result_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output ubxp_result_t out_data
);

  logic         out_valid_r;
  logic         skid_valid_r;
  ubxp_result_t out_data_r;
  ubxp_result_t skid_data_r;
  logic         take, acc;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign take      = out_valid_r && out_ready;
  assign acc       = in_valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_data;
    end else if (acc) begin
      skid_data_r <= in_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("beat taken during a stall was not kept");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> !skid_valid_r)
    else $error("skid entry not moved on when output was taken");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for ubx_nav_pvt_frame_parser: UBX frames are sent byte by byte
// and every output beat is compared with a behavioural decoder kept in step here.
// Depends on ubxp_pkg and the parser RTL only.
module testbench;
  import ubxp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAY_DEPTH    = DEF_PAYLOAD_BYTES;
  localparam int unsigned RANDOM_BEATS = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AT_BEAT = 700;

  typedef enum logic [3:0] {
    HUNT_B5, HUNT_62, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
    GET_PAYLOAD, GET_CK_A, GET_CK_B
  } parse_phase_e;

  typedef enum logic [1:0] { FILL_RANDOM, FILL_ZERO, FILL_ONES } fill_e;
  typedef enum logic [1:0] { CK_GOOD, CK_BAD_A, CK_BAD_B } fault_e;

  // one frame of stimulus; exp_status is the status of its last beat when pinned
  typedef struct packed {
    bit           lead_b5;
    logic [7:0]   cls;
    logic [7:0]   id;
    logic [15:0]  len;
    fill_e        fill;
    logic [7:0]   fix_raw;
    logic [31:0]  lat_raw;
    fault_e       fault;
    logic [63:0]  t_last;
    bit           pinned;
    ubxp_status_t exp_status;
  } frame_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // rx_byte[7:0], arrival_time[71:8]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // fix_kind .. fix_time, zero pad above
  logic [OUT_TUSER_W-1:0] out_tuser;  // status[2:0]

  ubx_nav_pvt_frame_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // decoder state, mirrors the parser
  parse_phase_e ph        = HUNT_B5;
  logic [7:0]   sum_lo    = '0;
  logic [7:0]   sum_hi    = '0;
  logic [7:0]   hdr_class = '0;
  logic [7:0]   msg_id    = '0;
  logic [15:0]  msg_len   = '0;
  logic [15:0]  pay_idx   = '0;
  logic [7:0]   pay_mem [PAY_DEPTH];

  ubxp_result_t decoded_q [$];
  int unsigned  tx_beats    = 0;
  int unsigned  rx_beats    = 0;
  int unsigned  mismatches  = 0;
  int unsigned  quiet_count = 0;
  bit           tx_steady   = 1'b0;

  frame_row_t dir_rows [15] = '{
    '{1'b0, NAV_CLASS, PVT_ID, 16'd92,  FILL_ZERO,   FIX_RAW_3D,      32'h0000_0000,
      CK_GOOD,  64'd0,                  1'b1, ST_OK},
    '{1'b0, NAV_CLASS, PVT_ID, 16'd92,  FILL_ONES,   FIX_RAW_2D,      32'hFFFF_FFFF,
      CK_GOOD,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OK},
    // latitude just past the positive limit saturates
    '{1'b0, NAV_CLASS, PVT_ID, 16'd128, FILL_RANDOM, FIX_RAW_GNSS_DR, 32'h4000_0000,
      CK_GOOD,  64'h0123_4567_89AB_CDEF, 1'b1, ST_OK},
    '{1'b0, NAV_CLASS, PVT_ID, 16'd100, FILL_RANDOM, 8'd0,            32'hBFFF_FFFF,
      CK_GOOD,  64'h8000_0000_0000_0000, 1'b1, ST_OK},
    '{1'b0, NAV_CLASS, PVT_ID, 16'd92,  FILL_RANDOM, 8'd255,          32'h7FFF_FFFF,
      CK_GOOD,  64'hDEAD_BEEF_0000_5555, 1'b1, ST_OK},
    '{1'b0, NAV_CLASS, PVT_ID, 16'd92,  FILL_RANDOM, FIX_RAW_3D,      32'h8000_0000,
      CK_GOOD,  64'h5555_AAAA_5555_AAAA, 1'b1, ST_OK},
    '{1'b0, NAV_CLASS, PVT_ID, 16'd91,  FILL_RANDOM, FIX_RAW_3D,      32'h0000_1000,
      CK_GOOD,  64'd17,                 1'b1, ST_MALFORMED},
    // oversized: tail bytes only feed the checksum
    '{1'b0, NAV_CLASS, PVT_ID, 16'd129, FILL_RANDOM, FIX_RAW_3D,      32'h0000_1000,
      CK_GOOD,  64'd18,                 1'b1, ST_MALFORMED},
    // zero length goes straight to the checksum
    '{1'b0, NAV_CLASS, PVT_ID, 16'd0,   FILL_RANDOM, 8'd0,            32'h0,
      CK_GOOD,  64'd20,                 1'b1, ST_MALFORMED},
    '{1'b0, 8'h02,     PVT_ID, 16'd8,   FILL_RANDOM, 8'd0,            32'h0,
      CK_GOOD,  64'd21,                 1'b1, ST_UNSUPPORTED},
    '{1'b0, NAV_CLASS, 8'h03,  16'd0,   FILL_RANDOM, 8'd0,            32'h0,
      CK_GOOD,  64'd22,                 1'b1, ST_UNSUPPORTED},
    '{1'b0, NAV_CLASS, PVT_ID, 16'd12,  FILL_RANDOM, FIX_RAW_3D,      32'h0,
      CK_BAD_A, 64'd23,                 1'b1, ST_CHECKSUM},
    '{1'b0, NAV_CLASS, PVT_ID, 16'd12,  FILL_RANDOM, FIX_RAW_3D,      32'h0,
      CK_BAD_B, 64'd24,                 1'b1, ST_CHECKSUM},
    // stray 0xB5 ahead of the sync pair: second byte 0xB5 drops the hunt
    '{1'b1, NAV_CLASS, PVT_ID, 16'd4,   FILL_ZERO,   FIX_RAW_3D,      32'h0,
      CK_GOOD,  64'd25,                 1'b1, ST_INCOMPLETE},
    '{1'b0, NAV_CLASS, PVT_ID, 16'd96,  FILL_RANDOM, FIX_RAW_2D,      32'h1234_5678,
      CK_GOOD,  64'd26,                 1'b1, ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void add_to_sums(input logic [7:0] b);
    sum_lo = sum_lo + b;
    sum_hi = sum_hi + sum_lo;
  endfunction

  function automatic void restart_hunt();
    ph      = HUNT_B5;
    msg_len = '0;
    pay_idx = '0;
  endfunction

  function automatic logic [31:0] word_at(input int unsigned ofs);
    return {pay_mem[ofs + 3], pay_mem[ofs + 2], pay_mem[ofs + 1], pay_mem[ofs]};
  endfunction

  // one byte through the decoder, returns the beat it should produce
  function automatic ubxp_result_t decode_byte(input logic [7:0] b, input logic [63:0] t);
    ubxp_result_t r;
    logic         ck_ok;
    logic [15:0]  len_now;
    logic [31:0]  lat;
    r = '0;
    r.status = ST_INCOMPLETE;
    case (ph)
      HUNT_B5: begin
        if (b == SYNC_FIRST) ph = HUNT_62;
      end
      HUNT_62: begin
        if (b == SYNC_SECOND) begin
          sum_lo = '0;
          sum_hi = '0;
          ph = GET_CLASS;
        end else begin
          ph = HUNT_B5;
        end
      end
      GET_CLASS: begin
        hdr_class = b;
        add_to_sums(b);
        ph = GET_ID;
      end
      GET_ID: begin
        msg_id = b;
        add_to_sums(b);
        ph = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        msg_len = {8'h00, b};
        add_to_sums(b);
        ph = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        msg_len[15:8] = b;
        add_to_sums(b);
        pay_idx = '0;
        if (msg_len == 16'd0) ph = GET_CK_A;
        else ph = GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        add_to_sums(b);
        if (pay_idx < PAY_DEPTH) pay_mem[pay_idx] = b;
        pay_idx = pay_idx + 16'd1;
        if (pay_idx >= msg_len) ph = GET_CK_A;
      end
      GET_CK_A: begin
        if (b != sum_lo) begin
          restart_hunt();
          r.status = ST_CHECKSUM;
        end else begin
          ph = GET_CK_B;
        end
      end
      GET_CK_B: begin
        ck_ok   = (b == sum_hi);
        len_now = msg_len;
        restart_hunt();
        if (!ck_ok) begin
          r.status = ST_CHECKSUM;
        end else if (hdr_class != NAV_CLASS || msg_id != PVT_ID) begin
          r.status = ST_UNSUPPORTED;
        end else if (len_now < PVT_MIN_LENGTH || len_now > PAY_DEPTH) begin
          r.status = ST_MALFORMED;
        end else begin
          r.status = ST_OK;
          case (pay_mem[OFS_FIX_TYPE])
            FIX_RAW_2D:                  r.fix_kind = FIX_2D;
            FIX_RAW_3D, FIX_RAW_GNSS_DR: r.fix_kind = FIX_3D;
            default:                     r.fix_kind = FIX_NONE;
          endcase
          r.satellite_count = pay_mem[OFS_NUM_SV];
          // clamp the 32-bit raw value into the 31-bit field
          lat = word_at(WORD_OFS[W_LAT]);
          if (!lat[31] && lat > 32'h3FFF_FFFF) lat = 32'h3FFF_FFFF;
          else if (lat[31] && lat < 32'hC000_0000) lat = 32'hC000_0000;
          r.latitude       = lat[30:0];
          r.longitude      = word_at(WORD_OFS[W_LON]);
          r.height         = word_at(WORD_OFS[W_HEIGHT]);
          r.horiz_accuracy = word_at(WORD_OFS[W_HACC]);
          r.vert_accuracy  = word_at(WORD_OFS[W_VACC]);
          r.ground_speed   = word_at(WORD_OFS[W_SPEED]);
          r.heading        = word_at(WORD_OFS[W_HEAD]);
          r.fix_time       = t;
        end
      end
      default: restart_hunt();
    endcase
    return r;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic [63:0] t,
                           input bit pinned, input ubxp_status_t pin_status);
    ubxp_result_t want;
    while (!tx_steady && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, b};
    do @(posedge clk); while (!in_tready);
    want = decode_byte(b, t);
    if (pinned) want.status = pin_status;
    decoded_q.push_back(want);
    tx_beats++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_row_t fr);
    logic [7:0]  body [$];
    logic [7:0]  frame_bytes [$];
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [7:0]  pb;
    logic [63:0] t;
    int unsigned k;
    body.push_back(fr.cls);
    body.push_back(fr.id);
    body.push_back(fr.len[7:0]);
    body.push_back(fr.len[15:8]);
    for (k = 0; k < fr.len; k++) begin
      case (fr.fill)
        FILL_ZERO: pb = 8'h00;
        FILL_ONES: pb = 8'hFF;
        default:   pb = 8'($urandom);
      endcase
      if (k == OFS_FIX_TYPE) pb = fr.fix_raw;
      if (k >= WORD_OFS[W_LAT] && k < WORD_OFS[W_LAT] + 4)
        pb = fr.lat_raw[8 * (k - WORD_OFS[W_LAT]) +: 8];
      body.push_back(pb);
    end
    sa = '0;
    sb = '0;
    foreach (body[i]) begin
      sa = sa + body[i];
      sb = sb + sa;
    end
    if (fr.lead_b5) frame_bytes.push_back(SYNC_FIRST);
    frame_bytes.push_back(SYNC_FIRST);
    frame_bytes.push_back(SYNC_SECOND);
    foreach (body[i]) frame_bytes.push_back(body[i]);
    case (fr.fault)
      CK_BAD_A: frame_bytes.push_back(sa ^ 8'($urandom_range(255, 1)));
      CK_BAD_B: begin
        frame_bytes.push_back(sa);
        frame_bytes.push_back(sb ^ 8'($urandom_range(255, 1)));
      end
      default: begin
        frame_bytes.push_back(sa);
        frame_bytes.push_back(sb);
      end
    endcase
    foreach (frame_bytes[i]) begin
      if (i == frame_bytes.size() - 1) begin
        send_beat(frame_bytes[i], fr.t_last, fr.pinned, fr.exp_status);
      end else begin
        t = {$urandom, $urandom};
        send_beat(frame_bytes[i], t, 1'b0, ST_INCOMPLETE);
      end
    end
  endtask

  function automatic frame_row_t random_frame(input int unsigned pick);
    frame_row_t fr;
    fr.lead_b5    = ($urandom_range(9) == 0);
    fr.cls        = NAV_CLASS;
    fr.id         = PVT_ID;
    fr.len        = 16'(PVT_MIN_LENGTH + $urandom_range(3));
    fr.fill       = ($urandom_range(19) == 0) ? fill_e'($urandom_range(2)) : FILL_RANDOM;
    fr.fix_raw    = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(5));
    fr.fault      = CK_GOOD;
    fr.t_last     = {$urandom, $urandom};
    fr.pinned     = 1'b0;
    fr.exp_status = ST_INCOMPLETE;
    case ($urandom_range(3))
      0: fr.lat_raw = $urandom;
      1: fr.lat_raw = 32'h3FFF_FFFE + $urandom_range(3);
      2: fr.lat_raw = 32'hBFFF_FFFE + $urandom_range(3);
      default: fr.lat_raw = 32'($urandom_range(1800000000)) - 32'd900000000;
    endcase
    if (pick < 45) begin
      if ($urandom_range(7) == 0) fr.len = 16'($urandom_range(PAY_DEPTH, PVT_MIN_LENGTH));
      if ($urandom_range(19) == 0) fr.fault = $urandom_range(1) ? CK_BAD_A : CK_BAD_B;
    end else if (pick < 55) begin
      case ($urandom_range(5))
        0:       fr.len = 16'($urandom_range(400, 200));
        1, 2:    fr.len = 16'($urandom_range(160, PAY_DEPTH + 1));
        default: fr.len = 16'($urandom_range(PVT_MIN_LENGTH - 1));
      endcase
    end else if (pick < 75) begin
      fr.len = 16'($urandom_range(20));
      case ($urandom_range(2))
        0:       fr.cls = 8'($urandom);
        1:       fr.id  = 8'($urandom);
        default: begin
          fr.cls = 8'($urandom);
          fr.id  = 8'($urandom);
        end
      endcase
    end else begin
      fr.len   = 16'($urandom_range(100));
      fr.fault = $urandom_range(1) ? CK_BAD_A : CK_BAD_B;
      if ($urandom_range(1)) fr.cls = 8'($urandom);
    end
    return fr;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ubxp_result_t want;
    ubxp_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      rx_beats++;
      got.status          = ubxp_status_t'(out_tuser[2:0]);
      got.fix_kind        = ubxp_fix_kind_t'(out_tdata[1:0]);
      got.satellite_count = out_tdata[9:2];
      got.latitude        = out_tdata[40:10];
      got.longitude       = out_tdata[72:41];
      got.height          = out_tdata[104:73];
      got.horiz_accuracy  = out_tdata[136:105];
      got.vert_accuracy   = out_tdata[168:137];
      got.ground_speed    = out_tdata[200:169];
      got.heading         = out_tdata[232:201];
      got.fix_time        = out_tdata[296:233];
      if (decoded_q.size() == 0) begin
        $error("result beat with no byte outstanding");
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        check_field("status",          want.status,          got.status);
        check_field("fix_kind",        want.fix_kind,        got.fix_kind);
        check_field("satellite_count", want.satellite_count, got.satellite_count);
        check_field("latitude",        want.latitude,        got.latitude);
        check_field("longitude",       want.longitude,       got.longitude);
        check_field("height",          want.height,          got.height);
        check_field("horiz_accuracy",  want.horiz_accuracy,  got.horiz_accuracy);
        check_field("vert_accuracy",   want.vert_accuracy,   got.vert_accuracy);
        check_field("ground_speed",    want.ground_speed,    got.ground_speed);
        check_field("heading",         want.heading,         got.heading);
        check_field("fix_time",        want.fix_time,        got.fix_time);
      end
    end
  end

  // stall watchdog: any accepted beat on either side clears it
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // sink: random back-pressure, one long hold-off, one stall-free stretch
  initial begin : sink
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!held && rx_beats >= HOLD_AT_BEAT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (rx_beats >= 200 && rx_beats < 550) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin : source
    frame_row_t  fr;
    int unsigned frame_no;
    int unsigned n_noise;
    int unsigned rand_start;
    int unsigned j;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      tx_steady = (i >= 5 && i < 10);
      send_frame(dir_rows[i]);
    end

    rand_start = tx_beats;
    frame_no   = 0;
    while (tx_beats - rand_start < RANDOM_BEATS) begin
      tx_steady = (frame_no >= 1 && frame_no < 3);
      if (frame_no == 0) begin
        // let the parser run dry before carrying on
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (decoded_q.size() != 0) @(negedge clk);
      end
      if ($urandom_range(99) < 15) begin
        n_noise = $urandom_range(6, 1);
        for (j = 0; j < n_noise; j++) begin
          case ($urandom_range(3))
            0:       send_beat(SYNC_FIRST, {$urandom, $urandom}, 1'b0, ST_INCOMPLETE);
            1:       send_beat(SYNC_SECOND, {$urandom, $urandom}, 1'b0, ST_INCOMPLETE);
            default: send_beat(8'($urandom), {$urandom, $urandom}, 1'b0, ST_INCOMPLETE);
          endcase
        end
      end else begin
        fr = random_frame($urandom_range(99));
        send_frame(fr);
      end
      frame_no++;
    end

    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
